[hw/rtl/fbfl_pkg.sv]
// Shared types, constants and codes for the fixed-block free-list allocator.
package fbfl_pkg;

  // Field and datapath widths
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int STRIDE_W  = 17;
  localparam int COUNT_W   = 9;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int MAX_BLOCKS_DEF   = 256;
  localparam int HEADER_BYTES_DEF = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  // Reset values of the registers
  localparam logic [ADDR_W-1:0]  REGION_START_RST = '0;
  localparam logic [SIZE_W-1:0]  BLOCK_BYTES_RST  = 16'd4;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST  = '0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LINK,
    ST_BUILD,
    ST_DONE
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [ADDR_W-1:0]   dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ADDR_W-1:0]   quotient;
    logic [STRIDE_W-1:0] remainder;
  } div_rsp_t;

endpackage

[hw/rtl/fixed_block_free_list_allocator.sv]
// Fixed-size block free-list allocator: LIFO list of block addresses in a link memory.
// Free and alloc map an address to a block index with the radix-2 divider (skipped by an
// alloc on an empty list); a build writes one link per cycle. One item is in work at a time;
// the next is taken once the result sits in the output register. Reset (synchronous) empties
// the list and loads register defaults; the link memory is not cleared.
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS   = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = fbfl_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbfl_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fbfl_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fbfl_pkg::out_item_t            out_data
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int AW    = fbfl_pkg::ADDR_W;

  fbfl_pkg::state_t state, state_next;

  // Configuration registers
  logic [AW-1:0]                 region_start;
  logic [fbfl_pkg::SIZE_W-1:0]   block_bytes;
  logic [fbfl_pkg::COUNT_W-1:0]  block_count;

  // Derived pool geometry
  logic [fbfl_pkg::SIZE_W-1:0]   bytes_eff;
  logic [fbfl_pkg::STRIDE_W-1:0] bytes_sum;
  logic [fbfl_pkg::STRIDE_W-1:0] stride;
  logic [CNT_W-1:0]              eff_count;
  logic [AW-1:0]                 first_block;

  // List state and item context
  logic [AW-1:0]                 head_address;
  logic [fbfl_pkg::KIND_W-1:0]   op;
  logic [AW-1:0]                 rel_addr;
  logic [AW-1:0]                 res_addr;
  logic                          res_status;
  logic [CNT_W-1:0]              build_cnt;
  logic [AW-1:0]                 build_addr;
  logic [AW-1:0]                 build_next;
  logic                          build_last;

  // Handshake and control
  logic                          in_fire;
  logic                          out_load;
  logic                          blk_ok;
  logic [IDX_W-1:0]              blk_idx;
  fbfl_pkg::div_req_t            div_req;
  fbfl_pkg::div_rsp_t            div_rsp;

  // Link memory
  logic [AW-1:0]                 link_mem [MAX_BLOCKS];
  logic                          link_we;
  logic [IDX_W-1:0]              link_waddr;
  logic [AW-1:0]                 link_wdata;
  logic                          link_re;
  logic [AW-1:0]                 link_rdata;

  // Stride is block size rounded up to four bytes; count is clamped to the memory depth
  always_comb begin
    bytes_eff   = (block_bytes == '0) ? fbfl_pkg::SIZE_W'(1) : block_bytes;
    bytes_sum   = fbfl_pkg::STRIDE_W'(bytes_eff) + fbfl_pkg::STRIDE_W'(3);
    stride      = {bytes_sum[fbfl_pkg::STRIDE_W-1:2], 2'b00};
    eff_count   = (17'(block_count) > 17'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                       : CNT_W'(block_count);
    first_block = region_start + AW'(HEADER_BYTES);
    build_next  = build_addr + AW'(stride);
    build_last  = build_cnt == (eff_count - CNT_W'(1));
    blk_ok      = (div_rsp.remainder == '0) && (div_rsp.quotient < AW'(eff_count));
    blk_idx     = div_rsp.quotient[IDX_W-1:0];
  end

  assign in_ready = state == fbfl_pkg::ST_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == fbfl_pkg::ST_DONE) && (!out_valid || out_ready);

  // Address-to-index divider
  fbfl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fbfl_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.kind)
            fbfl_pkg::KIND_BUILD:
              state_next = (eff_count != '0) ? fbfl_pkg::ST_BUILD : fbfl_pkg::ST_DONE;
            fbfl_pkg::KIND_ALLOC:
              state_next = (head_address != '0) ? fbfl_pkg::ST_DIV : fbfl_pkg::ST_DONE;
            fbfl_pkg::KIND_FREE:
              state_next = fbfl_pkg::ST_DIV;
            default:
              state_next = fbfl_pkg::ST_DONE;
          endcase
        end
      end
      fbfl_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = (op == fbfl_pkg::KIND_ALLOC && blk_ok) ? fbfl_pkg::ST_LINK
                                                               : fbfl_pkg::ST_DONE;
        end
      end
      fbfl_pkg::ST_LINK:  state_next = fbfl_pkg::ST_DONE;
      fbfl_pkg::ST_BUILD: state_next = build_last ? fbfl_pkg::ST_DONE : fbfl_pkg::ST_BUILD;
      fbfl_pkg::ST_DONE:  state_next = out_load ? fbfl_pkg::ST_IDLE : fbfl_pkg::ST_DONE;
      default:            state_next = fbfl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: divider start, link writes and reads
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = ((in_data.kind == fbfl_pkg::KIND_FREE) ? in_data.block_address
                                                               : head_address) - first_block;
    div_req.divisor  = stride;
    link_we          = 1'b0;
    link_waddr       = blk_idx;
    link_wdata       = head_address;
    link_re          = 1'b0;
    unique case (state)
      fbfl_pkg::ST_IDLE: begin
        div_req.start = in_fire && ((in_data.kind == fbfl_pkg::KIND_FREE) ||
                        (in_data.kind == fbfl_pkg::KIND_ALLOC && head_address != '0));
      end
      fbfl_pkg::ST_DIV: begin
        link_we = div_rsp.done && blk_ok && (op == fbfl_pkg::KIND_FREE);
        link_re = div_rsp.done && blk_ok && (op == fbfl_pkg::KIND_ALLOC);
      end
      fbfl_pkg::ST_BUILD: begin
        link_we    = 1'b1;
        link_waddr = build_cnt[IDX_W-1:0];
        link_wdata = build_last ? '0 : build_next;
      end
      default: begin
      end
    endcase
  end

  // Link memory, registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[blk_idx];
    end
  end

  // Control registers: state, configuration, head, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fbfl_pkg::ST_IDLE;
      region_start <= fbfl_pkg::REGION_START_RST;
      block_bytes  <= fbfl_pkg::BLOCK_BYTES_RST;
      block_count  <= fbfl_pkg::BLOCK_COUNT_RST;
      head_address <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          fbfl_pkg::REG_REGION_START: region_start <= cfg_data;
          fbfl_pkg::REG_BLOCK_BYTES:  block_bytes  <= cfg_data[fbfl_pkg::SIZE_W-1:0];
          fbfl_pkg::REG_BLOCK_COUNT:  block_count  <= cfg_data[fbfl_pkg::COUNT_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        fbfl_pkg::ST_IDLE: begin
          if (in_fire && in_data.kind == fbfl_pkg::KIND_BUILD) begin
            head_address <= (eff_count != '0) ? first_block : '0;
          end
        end
        fbfl_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            if (op == fbfl_pkg::KIND_ALLOC && !blk_ok) begin
              head_address <= '0;
            end else if (op == fbfl_pkg::KIND_FREE && blk_ok) begin
              head_address <= rel_addr;
            end
          end
        end
        fbfl_pkg::ST_LINK: head_address <= link_rdata;
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item context and result payload
  always_ff @(posedge clk) begin
    case (state)
      fbfl_pkg::ST_IDLE: begin
        if (in_fire) begin
          op         <= in_data.kind;
          rel_addr   <= in_data.block_address;
          res_addr   <= '0;
          res_status <= 1'b0;
          build_cnt  <= '0;
          build_addr <= first_block;
          case (in_data.kind)
            fbfl_pkg::KIND_BUILD: res_status <= 1'b1;
            fbfl_pkg::KIND_ALLOC: begin
              if (head_address != '0) begin
                res_addr   <= head_address;
                res_status <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      fbfl_pkg::ST_DIV: begin
        if (div_rsp.done && op == fbfl_pkg::KIND_FREE && blk_ok) begin
          res_status <= 1'b1;
        end
      end
      fbfl_pkg::ST_BUILD: begin
        build_addr <= build_next;
        build_cnt  <= build_cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data.address <= res_addr;
      out_data.status  <= res_status;
    end
  end

  // Divider results arrive only while an item waits on them
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == fbfl_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // A link read always follows a successful index lookup
  a_link_after_div: assert property (@(posedge clk) disable iff (rst)
    state == fbfl_pkg::ST_LINK |-> $past(state) == fbfl_pkg::ST_DIV && $past(link_re))
    else $error("link state entered without a read");

  // Alloc on an empty list finishes at once with failure
  a_alloc_empty: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.kind == fbfl_pkg::KIND_ALLOC && head_address == '0
    |=> state == fbfl_pkg::ST_DONE && !res_status && res_addr == '0)
    else $error("alloc on empty list did not fail");

  // The divider is never restarted while an item is being divided
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    state == fbfl_pkg::ST_DIV |-> !div_req.start)
    else $error("divider restarted mid-item");

endmodule

[hw/rtl/fbfl_div.sv]
// Radix-2 restoring divider: one quotient bit per cycle.
module fbfl_div (
  input  logic             clk,
  input  logic             rst,
  input  fbfl_pkg::div_req_t req,
  output fbfl_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(fbfl_pkg::ADDR_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(fbfl_pkg::ADDR_W - 1);

  logic                          busy;
  logic                          done;
  logic [CNT_W-1:0]              step;
  logic [fbfl_pkg::ADDR_W-1:0]   quo;
  logic [fbfl_pkg::STRIDE_W-1:0] rem;
  logic [fbfl_pkg::STRIDE_W-1:0] dvs;
  logic [fbfl_pkg::STRIDE_W:0]   trial;
  logic [fbfl_pkg::STRIDE_W:0]   diff;
  logic                          fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quo[fbfl_pkg::ADDR_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial-result registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[fbfl_pkg::ADDR_W-2:0], fits};
      rem <= fits ? diff[fbfl_pkg::STRIDE_W-1:0] : trial[fbfl_pkg::STRIDE_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the fixed-block free-list allocator.
module tb_top;

  localparam int HDR_BYTES      = fbfl_pkg::HEADER_BYTES_DEF;
  localparam int POOL_MAX       = fbfl_pkg::MAX_BLOCKS_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTS     = 200;
  localparam logic [fbfl_pkg::KIND_W-1:0] KIND_UNDEF = 2'd3;

  // Shadow of the allocator: registers, list head and link memory
  typedef struct packed {
    logic [fbfl_pkg::ADDR_W-1:0]               region;
    logic [fbfl_pkg::SIZE_W-1:0]               blk_bytes;
    logic [fbfl_pkg::COUNT_W-1:0]              blk_count;
    logic [fbfl_pkg::ADDR_W-1:0]               head;
    logic [POOL_MAX-1:0]                       written;
    logic [POOL_MAX-1:0][fbfl_pkg::ADDR_W-1:0] link;
  } pool_t;

  logic                           clk;
  logic                           rst        = 1'b1;
  logic                           cfg_wr_en  = 1'b0;
  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [fbfl_pkg::ADDR_W-1:0]    cfg_data   = '0;
  logic                           in_valid   = 1'b0;
  logic                           in_ready;
  fbfl_pkg::in_item_t             in_data    = '0;
  logic                           out_valid;
  logic                           out_ready  = 1'b0;
  fbfl_pkg::out_item_t            out_data;

  pool_t                          shadow_pool;   // advanced on accepted items
  pool_t                          plan_pool;     // advanced as stimulus is queued
  fbfl_pkg::in_item_t             request_queue[$];
  fbfl_pkg::out_item_t            predicted_replies[$];
  logic [fbfl_pkg::ADDR_W-1:0]    held_blocks[$];
  int                             mismatches   = 0;
  int                             send_gap     = 0;
  int                             hold_gap     = 0;
  int                             in_idle_pct  = 0;
  int                             out_idle_pct = 0;
  int                             quiet_cycles = 0;

  fixed_block_free_list_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pool geometry under the current registers
  function automatic logic [fbfl_pkg::STRIDE_W-1:0] stride_of(input pool_t p);
    logic [fbfl_pkg::STRIDE_W-1:0] b;
    b = (p.blk_bytes == '0) ? fbfl_pkg::STRIDE_W'(1) : fbfl_pkg::STRIDE_W'(p.blk_bytes);
    return (b + fbfl_pkg::STRIDE_W'(3)) & ~fbfl_pkg::STRIDE_W'(3);
  endfunction

  function automatic int unsigned eff_count(input pool_t p);
    return (p.blk_count > POOL_MAX) ? POOL_MAX : int'(p.blk_count);
  endfunction

  function automatic logic [fbfl_pkg::ADDR_W-1:0] first_of(input pool_t p);
    return p.region + fbfl_pkg::ADDR_W'(HDR_BYTES);
  endfunction

  // Address to block index; 0 when the address is not a block of the pool
  function automatic bit map_block(input pool_t p, input logic [fbfl_pkg::ADDR_W-1:0] a,
                                   output int unsigned idx);
    logic [fbfl_pkg::ADDR_W-1:0] d;
    int unsigned                 s;
    idx = 0;
    s = stride_of(p);
    d = a - first_of(p);
    if (d % s != 0) return 1'b0;
    if (d / s >= eff_count(p)) return 1'b0;
    idx = d / s;
    return 1'b1;
  endfunction

  // Applies one item to the pool and returns the reply it gives
  function automatic fbfl_pkg::out_item_t pool_apply(inout pool_t p,
                                                     input fbfl_pkg::in_item_t req);
    fbfl_pkg::out_item_t           r;
    int unsigned                   n;
    int unsigned                   idx;
    int unsigned                   i;
    logic [fbfl_pkg::ADDR_W-1:0]   a;
    logic [fbfl_pkg::STRIDE_W-1:0] s;
    r = '0;
    case (req.kind)
      fbfl_pkg::KIND_BUILD: begin
        n = eff_count(p);
        a = first_of(p);
        s = stride_of(p);
        for (i = 0; i < n; i++) begin
          a = a + s;
          p.link[i]    = (i + 1 < n) ? a : '0;
          p.written[i] = 1'b1;
        end
        p.head   = (n > 0) ? first_of(p) : '0;
        r.status = 1'b1;
      end
      fbfl_pkg::KIND_ALLOC: begin
        if (p.head != '0) begin
          r.address = p.head;
          r.status  = 1'b1;
          if (map_block(p, p.head, idx)) p.head = p.link[idx];
          else p.head = '0;
        end
      end
      fbfl_pkg::KIND_FREE: begin
        if (map_block(p, req.block_address, idx)) begin
          p.link[idx]    = p.head;
          p.written[idx] = 1'b1;
          p.head         = req.block_address;
          r.status       = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // True when an alloc would follow a link that was never written
  function automatic bit reads_unwritten(input pool_t p, input fbfl_pkg::in_item_t req);
    int unsigned idx;
    if (req.kind != fbfl_pkg::KIND_ALLOC || p.head == '0) return 1'b0;
    if (!map_block(p, p.head, idx)) return 1'b0;
    return !p.written[idx];
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Queue one item; an alloc that would hit an unwritten link becomes a build
  task automatic queue_item(input logic [fbfl_pkg::KIND_W-1:0] kind,
                            input logic [fbfl_pkg::ADDR_W-1:0] addr);
    fbfl_pkg::in_item_t  req;
    fbfl_pkg::out_item_t r;
    req.kind          = kind;
    req.block_address = addr;
    if (reads_unwritten(plan_pool, req)) req.kind = fbfl_pkg::KIND_BUILD;
    r = pool_apply(plan_pool, req);
    if (req.kind == fbfl_pkg::KIND_BUILD) held_blocks.delete();
    if (req.kind == fbfl_pkg::KIND_ALLOC && r.status) held_blocks.push_back(r.address);
    request_queue.push_back(req);
  endtask

  // Wait until the block has nothing in flight; checked between edges so the
  // driver and monitor updates of the last edge have settled
  task automatic drain();
    while (request_queue.size() != 0 || in_valid || predicted_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbfl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbfl_pkg::ADDR_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      fbfl_pkg::REG_REGION_START: begin
        shadow_pool.region = val;
        plan_pool.region   = val;
      end
      fbfl_pkg::REG_BLOCK_BYTES: begin
        shadow_pool.blk_bytes = val[fbfl_pkg::SIZE_W-1:0];
        plan_pool.blk_bytes   = val[fbfl_pkg::SIZE_W-1:0];
      end
      fbfl_pkg::REG_BLOCK_COUNT: begin
        shadow_pool.blk_count = val[fbfl_pkg::COUNT_W-1:0];
        plan_pool.blk_count   = val[fbfl_pkg::COUNT_W-1:0];
      end
      default: ;
    endcase
  endtask

  // Upper bits of the narrow registers carry noise
  task automatic set_pool(input logic [fbfl_pkg::ADDR_W-1:0]  region,
                          input logic [fbfl_pkg::SIZE_W-1:0]  nbytes,
                          input logic [fbfl_pkg::COUNT_W-1:0] ncount);
    logic [fbfl_pkg::ADDR_W-1:0] noise;
    noise = $urandom;
    write_reg(fbfl_pkg::REG_REGION_START, region);
    write_reg(fbfl_pkg::REG_BLOCK_BYTES,
              {noise[fbfl_pkg::ADDR_W-1:fbfl_pkg::SIZE_W], nbytes});
    write_reg(fbfl_pkg::REG_BLOCK_COUNT,
              {noise[fbfl_pkg::ADDR_W-1:fbfl_pkg::COUNT_W], ncount});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    held_blocks.delete();
  endtask

  task automatic random_config();
    logic [fbfl_pkg::SIZE_W-1:0]   nbytes;
    logic [fbfl_pkg::COUNT_W-1:0]  ncount;
    logic [fbfl_pkg::ADDR_W-1:0]   region;
    logic [fbfl_pkg::STRIDE_W-1:0] s;
    case ($urandom_range(0, 5))
      0:       nbytes = '0;
      1:       nbytes = '1;
      2:       nbytes = fbfl_pkg::SIZE_W'($urandom);
      default: nbytes = fbfl_pkg::SIZE_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 9))
      0:       ncount = '0;
      1:       ncount = fbfl_pkg::COUNT_W'(POOL_MAX);
      2:       ncount = fbfl_pkg::COUNT_W'($urandom_range(POOL_MAX + 1, 511));
      default: ncount = fbfl_pkg::COUNT_W'($urandom_range(1, 16));
    endcase
    s = ((nbytes == '0 ? 17'd1 : fbfl_pkg::STRIDE_W'(nbytes)) + 17'd3) & ~17'd3;
    case ($urandom_range(0, 5))
      0:       region = '0;
      1:       region = '1;
      // some block lands on address zero
      2:       region = -fbfl_pkg::ADDR_W'(HDR_BYTES) - s * $urandom_range(0, 3);
      default: region = $urandom;
    endcase
    set_pool(region, nbytes, ncount);
  endtask

  // Mostly alloc/free traffic on real blocks, with builds, bad frees and undefined kinds
  task automatic random_phase(input int n_items);
    int                            roll;
    int unsigned                   n;
    int                            k;
    logic [fbfl_pkg::ADDR_W-1:0]   fb;
    logic [fbfl_pkg::ADDR_W-1:0]   addr;
    logic [fbfl_pkg::STRIDE_W-1:0] s;
    if ($urandom_range(0, 4) != 0) queue_item(fbfl_pkg::KIND_BUILD, $urandom);
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      n    = eff_count(plan_pool);
      fb   = first_of(plan_pool);
      s    = stride_of(plan_pool);
      if (roll < 40) begin
        if (plan_pool.head == '0 && $urandom_range(0, 1) == 1)
          queue_item(fbfl_pkg::KIND_BUILD, $urandom);
        else
          queue_item(fbfl_pkg::KIND_ALLOC, $urandom);
      end else if (roll < 75) begin
        if (held_blocks.size() != 0) begin
          k    = $urandom_range(0, held_blocks.size() - 1);
          addr = held_blocks[k];
          held_blocks.delete(k);
          queue_item(fbfl_pkg::KIND_FREE, addr);
        end else begin
          queue_item(fbfl_pkg::KIND_ALLOC, $urandom);
        end
      end else if (roll < 80 && n != 0) begin
        // any block, possibly one already free
        queue_item(fbfl_pkg::KIND_FREE, fb + s * $urandom_range(0, n - 1));
      end else if (roll < 88) begin
        case ($urandom_range(0, 2))
          0:       addr = fb + s * $urandom_range(0, n) + $urandom_range(1, 3);
          1:       addr = $urandom_range(0, 1) ? fb + s * n : fb - s;
          default: addr = $urandom;
        endcase
        queue_item(fbfl_pkg::KIND_FREE, addr);
      end else if (roll < 94) begin
        queue_item(fbfl_pkg::KIND_BUILD, $urandom);
      end else begin
        queue_item(KIND_UNDEF, $urandom);
      end
    end
  endtask

  // Request driver; predicts the reply of each accepted item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) predicted_replies.push_back(pool_apply(shadow_pool, in_data));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          in_data  <= request_queue.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap(in_idle_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor with random back-pressure
  always @(posedge clk) begin
    fbfl_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          note_mismatch($sformatf("reply %h/%0d with none pending",
                                  out_data.address, out_data.status));
        end else begin
          want = predicted_replies.pop_front();
          if (out_data.address !== want.address)
            note_mismatch($sformatf("address got %h want %h", out_data.address, want.address));
          if (out_data.status !== want.status)
            note_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
        end
      end
      if (hold_gap != 0) begin
        hold_gap  <= hold_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_gap  <= pick_gap(out_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    shadow_pool           = '0;
    shadow_pool.region    = fbfl_pkg::REGION_START_RST;
    shadow_pool.blk_bytes = fbfl_pkg::BLOCK_BYTES_RST;
    shadow_pool.blk_count = fbfl_pkg::BLOCK_COUNT_RST;
    plan_pool             = shadow_pool;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: empty list, empty pool
    in_idle_pct  = 30;
    out_idle_pct = 30;
    queue_item(fbfl_pkg::KIND_ALLOC, '0);
    queue_item(fbfl_pkg::KIND_FREE, 32'd12);
    queue_item(fbfl_pkg::KIND_BUILD, '1);
    queue_item(KIND_UNDEF, '1);
    drain();

    // Zero block size taken as one; bad frees; double free
    set_pool(32'h0000_1000, '0, 9'd3);
    queue_item(fbfl_pkg::KIND_BUILD, '0);
    repeat (4) queue_item(fbfl_pkg::KIND_ALLOC, '0);
    queue_item(fbfl_pkg::KIND_FREE, 32'h0000_1010);
    queue_item(fbfl_pkg::KIND_FREE, 32'h0000_1011);
    queue_item(fbfl_pkg::KIND_FREE, 32'h0000_1018);
    queue_item(fbfl_pkg::KIND_FREE, 32'h0000_1008);
    queue_item(fbfl_pkg::KIND_FREE, 32'h0000_1010);
    repeat (2) queue_item(fbfl_pkg::KIND_ALLOC, '0);
    drain();

    // Widest stride, count above the maximum, block 1 wraps to address zero
    set_pool(32'hFFFE_FFF4, '1, '1);
    queue_item(fbfl_pkg::KIND_BUILD, '0);
    repeat (2) queue_item(fbfl_pkg::KIND_ALLOC, '0);
    queue_item(fbfl_pkg::KIND_FREE, 32'h0000_0000);
    queue_item(fbfl_pkg::KIND_ALLOC, '0);
    queue_item(fbfl_pkg::KIND_FREE, 32'hFFFF_0000);
    queue_item(fbfl_pkg::KIND_FREE, 32'hFFFF_FFFF);
    queue_item(fbfl_pkg::KIND_FREE, 32'h00FE_0000);
    queue_item(fbfl_pkg::KIND_ALLOC, '0);
    drain();

    // Registers changed under a live list: head no longer maps to a block
    set_pool('0, 16'd1, 9'd1);
    repeat (2) queue_item(fbfl_pkg::KIND_ALLOC, '0);
    queue_item(fbfl_pkg::KIND_BUILD, '0);
    queue_item(fbfl_pkg::KIND_ALLOC, '0);
    queue_item(fbfl_pkg::KIND_FREE, 32'd12);
    drain();

    // Random phases, every fourth without idling
    for (int ph = 0; ph < 12; ph++) begin
      in_idle_pct  = (ph % 4 == 3) ? 0 : 30;
      out_idle_pct = (ph % 4 == 3) ? 0 : 30;
      random_config();
      random_phase(160);
      drain();
    end

    repeat (40) @(posedge clk);
    if (predicted_replies.size() != 0)
      note_mismatch($sformatf("%0d replies never arrived", predicted_replies.size()));
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
